@@ hdl/robot_tick_motor_sequencer_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Tick motor sequencer: assertion macros
// Concurrent checks, compiled out for synthesis.
// ----------------------------------------------------------------------------
`ifndef ROBOT_TICK_MOTOR_SEQUENCER_UNIT_MACROS_SVH
`define ROBOT_TICK_MOTOR_SEQUENCER_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Check that is switched off during reset
`define RTSQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that also holds during reset
`define RTSQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RTSQ_ASSERT(lbl, prop, msg)
`define RTSQ_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hdl/rtsq_pkg.sv @@
// ----------------------------------------------------------------------------
// Tick motor sequencer package
// Shared types, register map, reset values, drive patterns and decoders.
// ----------------------------------------------------------------------------
package rtsq_pkg;

  // Register map (word index)
  localparam int unsigned CFG_ADDR_W = 5;
  localparam logic [2:0] REG_DUTY      = 3'd0;
  localparam logic [2:0] REG_PERIOD    = 3'd1;
  localparam logic [2:0] REG_LIGHT     = 3'd2;
  localparam logic [2:0] REG_IR_FILT   = 3'd3;
  localparam logic [2:0] REG_IR_HALF   = 3'd4;
  localparam logic [2:0] REG_ESC_HOLD  = 3'd5;

  // Register reset values
  localparam logic [7:0]  DUTY_RST     = 8'd95;
  localparam logic [7:0]  PERIOD_RST   = 8'd100;
  localparam logic [7:0]  LIGHT_RST    = 8'd200;
  localparam logic [7:0]  IR_FILT_RST  = 8'd100;
  localparam logic [3:0]  IR_HALF_RST  = 4'd3;
  localparam logic [12:0] ESC_HOLD_RST = 13'd5000;

  // Motor drive patterns
  localparam logic [7:0] CRUISE_ON  = 8'b0110_1100;
  localparam logic [7:0] CRUISE_OFF = 8'b0100_1000;
  localparam logic [7:0] AVOID_ON   = 8'b0010_1100;
  localparam logic [7:0] AVOID_OFF  = 8'b0010_1000;

  // Bumper ladder thresholds
  localparam logic [7:0] BUMP_TH7 = 8'd137;
  localparam logic [7:0] BUMP_TH5 = 8'd116;
  localparam logic [7:0] BUMP_TH6 = 8'd95;
  localparam logic [7:0] BUMP_TH4 = 8'd74;
  localparam logic [7:0] BUMP_TH3 = 8'd52;
  localparam logic [7:0] BUMP_TH1 = 8'd31;
  localparam logic [7:0] BUMP_TH2 = 8'd10;

  typedef enum logic [2:0] {
    MODE_STOP   = 3'd0,
    MODE_BLIND  = 3'd1,
    MODE_AVOID  = 3'd2,
    MODE_ESCAPE = 3'd3,
    MODE_CRUISE = 3'd4
  } mode_t;

  typedef struct packed {
    logic [12:0] escape_hold_ticks;
    logic [3:0]  ir_half_period_ticks;
    logic [7:0]  ir_filter_limit;
    logic [7:0]  light_limit;
    logic [7:0]  pwm_period_ticks;
    logic [7:0]  duty_ticks;
  } rtsq_cfg_t;

  typedef struct packed {
    logic [1:0] port_pins;
    logic       ir_receiver;
    logic [7:0] bumper_level;
    logic [7:0] light_level;
  } rtsq_in_t;

  typedef struct packed {
    mode_t      active_mode;
    logic       obstacle_flag;
    logic       ir_emitter;
    logic       motor_port_write;
    logic [7:0] motor_port_value;
  } rtsq_out_t;

  // Ladder level to bumper code
  function automatic logic [2:0] bump_decode(input logic [7:0] lvl);
    logic [2:0] code;
    if (lvl > BUMP_TH7)      code = 3'd7;
    else if (lvl > BUMP_TH5) code = 3'd5;
    else if (lvl > BUMP_TH6) code = 3'd6;
    else if (lvl > BUMP_TH4) code = 3'd4;
    else if (lvl > BUMP_TH3) code = 3'd3;
    else if (lvl > BUMP_TH1) code = 3'd1;
    else if (lvl > BUMP_TH2) code = 3'd2;
    else                     code = 3'd0;
    return code;
  endfunction

  // Escape on pattern per bumper code; codes 0 and 5..7 load nothing
  function automatic logic [7:0] esc_on(input logic [2:0] code);
    logic [7:0] p;
    case (code)
      3'd1:    p = 8'hAC;
      3'd2:    p = 8'h74;
      3'd3:    p = 8'hB4;
      3'd4:    p = 8'h6C;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  function automatic logic [7:0] esc_off(input logic [2:0] code);
    logic [7:0] p;
    case (code)
      3'd1:    p = 8'h88;
      3'd2:    p = 8'h50;
      3'd3:    p = 8'h90;
      3'd4:    p = 8'h48;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  function automatic logic esc_loads(input logic [2:0] code);
    return (code >= 3'd1) && (code <= 3'd4);
  endfunction

endpackage

@@ hdl/rtsq_cfg.sv @@
// ----------------------------------------------------------------------------
// Tick motor sequencer: configuration registers
// APB-style register file, always ready, six registers at word addresses.
// ----------------------------------------------------------------------------
module rtsq_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [rtsq_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]                    cfg_pwdata,
  output logic [31:0]                    cfg_prdata,
  output logic                           cfg_pready,
  output rtsq_pkg::rtsq_cfg_t            cfg
);
  import rtsq_pkg::*;

  rtsq_cfg_t  cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx        = cfg_paddr[CFG_ADDR_W-1:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  // Register writes; out-of-range indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duty_ticks           <= DUTY_RST;
      cfg_r.pwm_period_ticks     <= PERIOD_RST;
      cfg_r.light_limit          <= LIGHT_RST;
      cfg_r.ir_filter_limit      <= IR_FILT_RST;
      cfg_r.ir_half_period_ticks <= IR_HALF_RST;
      cfg_r.escape_hold_ticks    <= ESC_HOLD_RST;
    end else if (wr_en) begin
      case (idx)
        REG_DUTY:     cfg_r.duty_ticks           <= cfg_pwdata[7:0];
        REG_PERIOD:   cfg_r.pwm_period_ticks     <= cfg_pwdata[7:0];
        REG_LIGHT:    cfg_r.light_limit          <= cfg_pwdata[7:0];
        REG_IR_FILT:  cfg_r.ir_filter_limit      <= cfg_pwdata[7:0];
        REG_IR_HALF:  cfg_r.ir_half_period_ticks <= cfg_pwdata[3:0];
        REG_ESC_HOLD: cfg_r.escape_hold_ticks    <= cfg_pwdata[12:0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_DUTY:     cfg_prdata = {24'd0, cfg_r.duty_ticks};
      REG_PERIOD:   cfg_prdata = {24'd0, cfg_r.pwm_period_ticks};
      REG_LIGHT:    cfg_prdata = {24'd0, cfg_r.light_limit};
      REG_IR_FILT:  cfg_prdata = {24'd0, cfg_r.ir_filter_limit};
      REG_IR_HALF:  cfg_prdata = {28'd0, cfg_r.ir_half_period_ticks};
      REG_ESC_HOLD: cfg_prdata = {19'd0, cfg_r.escape_hold_ticks};
      default:      cfg_prdata = 32'd0;
    endcase
  end

endmodule

@@ hdl/rtsq_core.sv @@
// ----------------------------------------------------------------------------
// Tick motor sequencer: tick engine
// Holds the sequencer state and computes each tick combinationally:
// PWM off edge, IR emitter and echo filter, behaviours, period arbitration.
// ----------------------------------------------------------------------------
`include "robot_tick_motor_sequencer_unit_macros.svh"

module rtsq_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  rtsq_pkg::rtsq_in_t  tick,
  input  rtsq_pkg::rtsq_cfg_t cfg,
  output rtsq_pkg::rtsq_out_t res
);
  import rtsq_pkg::*;

  // State registers
  logic [7:0]  period_count_r, period_count_nxt;
  logic [7:0]  pwm_count_r, pwm_count_nxt;
  logic        pwm_running_r, pwm_running_nxt;
  logic [7:0]  on_pattern_r, on_pattern_nxt;
  logic [7:0]  off_pattern_r, off_pattern_nxt;
  logic [3:0]  ir_tick_count_r, ir_tick_count_nxt;
  logic        ir_phase_r, ir_phase_nxt;
  logic        echo_lit_r, echo_lit_nxt;
  logic        echo_dark_r, echo_dark_nxt;
  logic [7:0]  echo_filter_count_r, echo_filter_count_nxt;
  logic        obstacle_seen_r, obstacle_seen_nxt;
  logic [12:0] escape_timer_r, escape_timer_nxt;
  logic        escape_active_r, escape_active_nxt;
  logic [2:0]  escape_code_r, escape_code_nxt;
  logic        cruise_armed_r, cruise_armed_nxt;

  logic        period_hit;

  // One tick of work
  always_comb begin
    logic [7:0] port_val;
    logic       port_wr;
    logic       blind_now;
    logic       avoid_now;
    logic [2:0] code;
    logic [7:0] on_x;
    mode_t      mode;

    period_count_nxt      = period_count_r;
    pwm_count_nxt         = pwm_count_r;
    pwm_running_nxt       = pwm_running_r;
    on_pattern_nxt        = on_pattern_r;
    off_pattern_nxt       = off_pattern_r;
    ir_tick_count_nxt     = ir_tick_count_r;
    ir_phase_nxt          = ir_phase_r;
    echo_lit_nxt          = echo_lit_r;
    echo_dark_nxt         = echo_dark_r;
    echo_filter_count_nxt = echo_filter_count_r;
    obstacle_seen_nxt     = obstacle_seen_r;
    escape_timer_nxt      = escape_timer_r;
    escape_active_nxt     = escape_active_r;
    escape_code_nxt       = escape_code_r;
    cruise_armed_nxt      = cruise_armed_r;
    port_val              = 8'd0;
    port_wr               = 1'b0;
    blind_now             = 1'b0;
    avoid_now             = 1'b0;
    code                  = bump_decode(tick.bumper_level);
    on_x                  = on_pattern_r ^ {6'd0, tick.port_pins};
    period_hit            = 1'b0;

    // PWM off edge
    if (pwm_running_r) begin
      pwm_count_nxt = pwm_count_r + 8'd1;
      if (pwm_count_nxt == cfg.duty_ticks) begin
        off_pattern_nxt = off_pattern_r ^ {6'd0, tick.port_pins};
        port_val        = off_pattern_nxt;
        port_wr         = 1'b1;
        pwm_count_nxt   = 8'd0;
        pwm_running_nxt = 1'b0;
      end
    end

    // IR emitter toggle and echo filter
    ir_tick_count_nxt = ir_tick_count_r + 4'd1;
    if (ir_tick_count_nxt >= cfg.ir_half_period_ticks) begin
      ir_tick_count_nxt = 4'd0;
      if (!ir_phase_r) begin
        echo_lit_nxt = tick.ir_receiver;
        ir_phase_nxt = 1'b1;
      end else begin
        echo_dark_nxt = tick.ir_receiver;
        ir_phase_nxt  = 1'b0;
      end
      if (echo_lit_nxt && !echo_dark_nxt) begin
        echo_filter_count_nxt = echo_filter_count_r + 8'd1;
        if (echo_filter_count_nxt > cfg.ir_filter_limit) begin
          obstacle_seen_nxt     = 1'b1;
          echo_filter_count_nxt = 8'd0;
        end
      end else begin
        obstacle_seen_nxt     = 1'b0;
        echo_filter_count_nxt = 8'd0;
      end
    end

    // Behaviours; escape hold freezes evaluation
    if (escape_active_r && (escape_timer_r != 13'd0)) begin
      escape_timer_nxt = escape_timer_r - 13'd1;
    end else begin
      blind_now = tick.light_level > cfg.light_limit;
      if (!blind_now) begin
        avoid_now = obstacle_seen_nxt;
        if (!avoid_now) begin
          if (code != 3'd0) begin
            escape_active_nxt = 1'b1;
            escape_code_nxt   = code;
            escape_timer_nxt  = (cfg.escape_hold_ticks != 13'd0) ?
                                cfg.escape_hold_ticks - 13'd1 : 13'd0;
          end else begin
            escape_active_nxt = 1'b0;
          end
        end
      end
      if (!escape_active_nxt && !avoid_now && !blind_now) begin
        cruise_armed_nxt = 1'b1;
      end
    end

    // Priority
    if (blind_now)              mode = MODE_BLIND;
    else if (avoid_now)         mode = MODE_AVOID;
    else if (escape_active_nxt) mode = MODE_ESCAPE;
    else if (cruise_armed_nxt)  mode = MODE_CRUISE;
    else                        mode = MODE_STOP;

    // Period start: write on pattern, then load the next patterns
    period_count_nxt = period_count_r + 8'd1;
    if (period_count_nxt >= cfg.pwm_period_ticks) begin
      period_hit       = 1'b1;
      period_count_nxt = 8'd0;
      port_val         = on_x;
      port_wr          = 1'b1;
      pwm_running_nxt  = 1'b1;
      on_pattern_nxt   = on_x;
      case (mode)
        MODE_AVOID: begin
          on_pattern_nxt  = AVOID_ON;
          off_pattern_nxt = AVOID_OFF;
        end
        MODE_ESCAPE: begin
          if (esc_loads(escape_code_nxt)) begin
            on_pattern_nxt  = esc_on(escape_code_nxt);
            off_pattern_nxt = esc_off(escape_code_nxt);
          end
        end
        MODE_CRUISE: begin
          on_pattern_nxt  = CRUISE_ON;
          off_pattern_nxt = CRUISE_OFF;
        end
        default: begin
          on_pattern_nxt  = 8'd0;
          off_pattern_nxt = 8'd0;
        end
      endcase
    end

    res.motor_port_value = port_val;
    res.motor_port_write = port_wr;
    res.ir_emitter       = ir_phase_nxt;
    res.obstacle_flag    = obstacle_seen_nxt;
    res.active_mode      = mode;
  end

  // State update on each accepted tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_count_r      <= 8'd0;
      pwm_count_r         <= 8'd0;
      pwm_running_r       <= 1'b1;
      on_pattern_r        <= 8'd0;
      off_pattern_r       <= 8'd0;
      ir_tick_count_r     <= 4'd0;
      ir_phase_r          <= 1'b1;
      echo_lit_r          <= 1'b0;
      echo_dark_r         <= 1'b0;
      echo_filter_count_r <= 8'd0;
      obstacle_seen_r     <= 1'b0;
      escape_timer_r      <= 13'd0;
      escape_active_r     <= 1'b0;
      escape_code_r       <= 3'd0;
      cruise_armed_r      <= 1'b0;
    end else if (step) begin
      period_count_r      <= period_count_nxt;
      pwm_count_r         <= pwm_count_nxt;
      pwm_running_r       <= pwm_running_nxt;
      on_pattern_r        <= on_pattern_nxt;
      off_pattern_r       <= off_pattern_nxt;
      ir_tick_count_r     <= ir_tick_count_nxt;
      ir_phase_r          <= ir_phase_nxt;
      echo_lit_r          <= echo_lit_nxt;
      echo_dark_r         <= echo_dark_nxt;
      echo_filter_count_r <= echo_filter_count_nxt;
      obstacle_seen_r     <= obstacle_seen_nxt;
      escape_timer_r      <= escape_timer_nxt;
      escape_active_r     <= escape_active_nxt;
      escape_code_r       <= escape_code_nxt;
      cruise_armed_r      <= cruise_armed_nxt;
    end
  end

  // A running hold timer always belongs to an active escape
  `RTSQ_ASSERT_ALWAYS(a_timer_needs_escape, (escape_timer_r != 13'd0) |-> escape_active_r, "escape timer running without escape")
  // Period start re-arms the PWM
  `RTSQ_ASSERT(a_period_rearms, (step && period_hit) |=> pwm_running_r, "period start did not rearm PWM")
  // Obstacle flag comes up with a cleared filter count
  `RTSQ_ASSERT(a_obstacle_clears, $rose(obstacle_seen_r) |-> (echo_filter_count_r == 8'd0), "filter count not cleared on obstacle")
  // No tick, no state change
  `RTSQ_ASSERT(a_hold_without_step, !step |=> ($stable(period_count_r) && $stable(cruise_armed_r)), "state moved without a tick")

endmodule

@@ hdl/robot_tick_motor_sequencer_unit.sv @@
// ----------------------------------------------------------------------------
// Robot tick motor sequencer
// Usage:
//   in_*  : one transfer per 200 us tick (light, bumper, IR receiver, pins).
//   out_* : one result transfer per tick (motor port byte and write strobe,
//           IR emitter level, obstacle flag, active behaviour).
//   cfg_* : APB-style register port, pready always high; write only while
//           no tick is in flight.
// Path: each tick passes the input register, then the result register,
//   before its result is presented; a low out_tready can hold it in
//   either register.
// Throughput: one tick per cycle while out_tready stays high; the tick
//   engine updates all state on each accepted tick, and the input register
//   lets the next tick enter while a result is still waiting.
// Reset: synchronous, active low; clears both stage valids, the sequencer
//   state and loads the register defaults.
// Stall: when out_tready is low the result register holds, the input
//   register fills, then in_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module robot_tick_motor_sequencer_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Tick input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // light_level[7:0], bumper_level[15:8],
                                  // ir_receiver[16], port_pins[18:17], zero
  // Result output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // motor_port_value[7:0], motor_port_write[8],
                                  // ir_emitter[9], obstacle_flag[10],
                                  // active_mode[13:11], zero
  // Configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [4:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import rtsq_pkg::*;

  rtsq_cfg_t cfg;
  rtsq_in_t  in_r;
  logic      in_vld_r;
  rtsq_out_t res;
  rtsq_out_t out_r;
  logic      out_vld_r;
  logic      advance;

  // Tick moves into the result stage when that stage is free or draining
  assign advance   = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_r <= in_tdata[18:0];
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= 1'b1;
    end else if (out_tready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r <= res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {2'd0, out_r};

  rtsq_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  rtsq_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .tick  (in_r),
    .cfg   (cfg),
    .res   (res)
  );

endmodule

@@ tb/robot_tick_motor_sequencer_unit_tb.sv @@
// ----------------------------------------------------------------------------
// Tick motor sequencer testbench
// Streams tick transfers into the sequencer and checks every result transfer
// against a cycle-free model of the PWM, IR echo filter and behaviour
// arbitration. Registers are set over the APB port between phases and read
// back. Both stream sides idle at random in the early phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module robot_tick_motor_sequencer_unit_tb;
  import rtsq_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASES      = 7;
  localparam int PHASE_TICKS = 250;

  // Unused register slots past the map
  localparam logic [2:0] REG_SPARE_A = 3'd6;
  localparam logic [2:0] REG_SPARE_B = 3'd7;

  typedef enum int {SEG_CRUISE, SEG_ECHO, SEG_BUMP, SEG_BLIND, SEG_NOISE} seg_kind_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata = '0;    // light_level[7:0], bumper_level[15:8],
                                 // ir_receiver[16], port_pins[18:17], zero
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // motor_port_value[7:0], motor_port_write[8],
                                 // ir_emitter[9], obstacle_flag[10],
                                 // active_mode[13:11], zero
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [4:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  robot_tick_motor_sequencer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Model configuration
  logic [7:0]  cf_duty, cf_period, cf_light, cf_filt;
  logic [3:0]  cf_half;
  logic [12:0] cf_hold;

  // Model state
  logic [7:0]  period_cnt, pwm_cnt, on_pat, off_pat, echo_cnt;
  logic [3:0]  ir_cnt;
  logic [12:0] esc_timer;
  logic [2:0]  esc_code;
  logic        pwm_on, ir_ph, lit_smp, dark_smp, obst, esc_act, cruise_arm;

  // Emitter phase as seen by the stimulus generator
  logic [3:0]  gen_ir_cnt;
  logic        gen_ir_ph;

  rtsq_in_t    pending_ticks[$];
  rtsq_out_t   expected_results[$];
  rtsq_in_t    drive_item;
  logic        tick_taken = 1'b0;
  int          send_idle_pct = 0;
  int          recv_idle_pct = 0;
  int          error_count = 0;
  int          cycle_count = 0;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < 40)
      $display("[%0t] mismatch: %s got %0d want %0d", $time, what, got, want);
    error_count++;
  endtask

  function automatic logic [2:0] bumper_code(input logic [7:0] lvl);
    if (lvl > BUMP_TH7) return 3'd7;
    if (lvl > BUMP_TH5) return 3'd5;
    if (lvl > BUMP_TH6) return 3'd6;
    if (lvl > BUMP_TH4) return 3'd4;
    if (lvl > BUMP_TH3) return 3'd3;
    if (lvl > BUMP_TH1) return 3'd1;
    if (lvl > BUMP_TH2) return 3'd2;
    return 3'd0;
  endfunction

  // Escape drive per bumper code; codes 0 and 5..7 load nothing
  function automatic logic escape_drive(input logic [2:0] code,
                                        output logic [7:0] on_p, output logic [7:0] off_p);
    on_p = 8'h00;
    off_p = 8'h00;
    case (code)
      3'd1: begin on_p = 8'hAC; off_p = 8'h88; end
      3'd2: begin on_p = 8'h74; off_p = 8'h50; end
      3'd3: begin on_p = 8'hB4; off_p = 8'h90; end
      3'd4: begin on_p = 8'h6C; off_p = 8'h48; end
      default: return 1'b0;
    endcase
    return 1'b1;
  endfunction

  function automatic void model_reset();
    cf_duty = DUTY_RST;  cf_period = PERIOD_RST; cf_light = LIGHT_RST;
    cf_filt = IR_FILT_RST; cf_half = IR_HALF_RST; cf_hold = ESC_HOLD_RST;
    period_cnt = '0; pwm_cnt = '0; pwm_on = 1'b1; on_pat = '0; off_pat = '0;
    ir_cnt = '0; ir_ph = 1'b1; lit_smp = 1'b0; dark_smp = 1'b0; echo_cnt = '0;
    obst = 1'b0; esc_timer = '0; esc_act = 1'b0; esc_code = '0; cruise_arm = 1'b0;
    gen_ir_cnt = '0; gen_ir_ph = 1'b1;
  endfunction

  function automatic void model_config(input logic [2:0] idx, input logic [31:0] v);
    case (idx)
      REG_DUTY:     cf_duty = v[7:0];
      REG_PERIOD:   cf_period = v[7:0];
      REG_LIGHT:    cf_light = v[7:0];
      REG_IR_FILT:  cf_filt = v[7:0];
      REG_IR_HALF:  cf_half = v[3:0];
      REG_ESC_HOLD: cf_hold = v[12:0];
      default: ;
    endcase
  endfunction

  function automatic logic [31:0] model_reg(input logic [2:0] idx);
    case (idx)
      REG_DUTY:     return {24'd0, cf_duty};
      REG_PERIOD:   return {24'd0, cf_period};
      REG_LIGHT:    return {24'd0, cf_light};
      REG_IR_FILT:  return {24'd0, cf_filt};
      REG_IR_HALF:  return {28'd0, cf_half};
      REG_ESC_HOLD: return {19'd0, cf_hold};
      default:      return 32'd0;
    endcase
  endfunction

  // One tick: PWM off edge, IR echo filter, behaviours, period start
  function automatic rtsq_out_t sequence_tick(input rtsq_in_t t);
    rtsq_out_t  r;
    logic [7:0] port_val, on_p, off_p;
    logic       port_wr, blind, avoid;
    logic [2:0] code;
    mode_t      mode;
    port_val = '0;
    port_wr = 1'b0;
    blind = 1'b0;
    avoid = 1'b0;

    if (pwm_on) begin
      pwm_cnt = pwm_cnt + 8'd1;
      if (pwm_cnt == cf_duty) begin
        off_pat = off_pat ^ {6'd0, t.port_pins};
        port_val = off_pat;
        port_wr = 1'b1;
        pwm_cnt = '0;
        pwm_on = 1'b0;
      end
    end

    ir_cnt = ir_cnt + 4'd1;
    if (ir_cnt >= cf_half) begin
      ir_cnt = '0;
      if (!ir_ph) begin
        lit_smp = t.ir_receiver;
        ir_ph = 1'b1;
      end else begin
        dark_smp = t.ir_receiver;
        ir_ph = 1'b0;
      end
      if (lit_smp && !dark_smp) begin
        echo_cnt = echo_cnt + 8'd1;
        if (echo_cnt > cf_filt) begin
          obst = 1'b1;
          echo_cnt = '0;
        end
      end else begin
        obst = 1'b0;
        echo_cnt = '0;
      end
    end

    // escape hold ignores light and obstacle
    if (esc_act && esc_timer != 13'd0) begin
      esc_timer = esc_timer - 13'd1;
    end else begin
      blind = t.light_level > cf_light;
      if (!blind) begin
        avoid = obst;
        if (!avoid) begin
          code = bumper_code(t.bumper_level);
          if (code != 3'd0) begin
            esc_act = 1'b1;
            esc_code = code;
            esc_timer = (cf_hold != 13'd0) ? cf_hold - 13'd1 : 13'd0;
          end else begin
            esc_act = 1'b0;
          end
        end
      end
      if (!esc_act && !avoid && !blind) cruise_arm = 1'b1;
    end

    if (blind)           mode = MODE_BLIND;
    else if (avoid)      mode = MODE_AVOID;
    else if (esc_act)    mode = MODE_ESCAPE;
    else if (cruise_arm) mode = MODE_CRUISE;
    else                 mode = MODE_STOP;

    period_cnt = period_cnt + 8'd1;
    if (period_cnt >= cf_period) begin
      period_cnt = '0;
      on_pat = on_pat ^ {6'd0, t.port_pins};
      port_val = on_pat;
      port_wr = 1'b1;
      pwm_on = 1'b1;
      case (mode)
        MODE_AVOID: begin
          on_pat = AVOID_ON;
          off_pat = AVOID_OFF;
        end
        MODE_ESCAPE: begin
          if (escape_drive(esc_code, on_p, off_p)) begin
            on_pat = on_p;
            off_pat = off_p;
          end
        end
        MODE_CRUISE: begin
          on_pat = CRUISE_ON;
          off_pat = CRUISE_OFF;
        end
        default: begin
          on_pat = '0;
          off_pat = '0;
        end
      endcase
    end

    r.motor_port_value = port_val;
    r.motor_port_write = port_wr;
    r.ir_emitter = ir_ph;
    r.obstacle_flag = obst;
    r.active_mode = mode;
    return r;
  endfunction

  // Queue one tick; echo ticks answer the emitter so the filter counts up
  task automatic queue_tick(input logic [7:0] light, input logic [7:0] bump,
                            input logic rx, input logic echo, input logic [1:0] pins);
    rtsq_in_t t;
    t.light_level = light;
    t.bumper_level = bump;
    t.ir_receiver = rx;
    t.port_pins = pins;
    gen_ir_cnt = gen_ir_cnt + 4'd1;
    if (gen_ir_cnt >= cf_half) begin
      gen_ir_cnt = '0;
      if (echo) t.ir_receiver = !gen_ir_ph;
      gen_ir_ph = !gen_ir_ph;
    end
    pending_ticks.push_back(t);
  endtask

  task automatic queue_random(input int count);
    seg_kind_t  kind;
    int         seg_left, pick, lim, i;
    logic [7:0] light, bump, contact;
    logic       echo;
    kind = SEG_CRUISE;
    seg_left = 0;
    contact = 8'd11;
    lim = int'(cf_light);
    for (i = 0; i < count; i++) begin
      if (seg_left == 0) begin
        pick = $urandom_range(9, 0);
        if (pick < 3)       kind = SEG_CRUISE;
        else if (pick < 6)  kind = SEG_ECHO;
        else if (pick < 8)  kind = SEG_BUMP;
        else if (pick == 8) kind = SEG_BLIND;
        else                kind = SEG_NOISE;
        seg_left = $urandom_range(40, 4);
        if (kind == SEG_ECHO && cf_filt <= 8)
          seg_left = seg_left + (cf_filt + 1) * (cf_half + 1) * 2;
        contact = 8'($urandom_range(255, 11));
      end
      seg_left--;
      light = 8'($urandom_range(lim, 0));
      bump = 8'($urandom_range(BUMP_TH2, 0));
      echo = 1'b0;
      case (kind)
        SEG_ECHO:  echo = 1'b1;
        SEG_BUMP:  if ($urandom_range(2, 0) == 0) bump = contact;
        SEG_BLIND: light = (lim == 255) ? 8'($urandom_range(255, 0))
                                        : 8'($urandom_range(255, lim + 1));
        SEG_NOISE: begin
          light = 8'($urandom_range(255, 0));
          bump = 8'($urandom_range(255, 0));
        end
        default: ;
      endcase
      queue_tick(light, bump, 1'($urandom_range(1, 0)), echo, 2'($urandom_range(3, 0)));
    end
  endtask

  task automatic wait_idle();
    while (pending_ticks.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val, input int width);
    logic [31:0] raw;
    // junk above the field width must be dropped by the block
    raw = (width < 32) ? (val | ($urandom() << width)) : val;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {idx, 2'b00};
    cfg_pwdata <= raw;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    model_config(idx, raw);
  endtask

  task automatic reg_readback(input logic [2:0] idx);
    logic [31:0] got;
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    cfg_paddr <= {idx, 2'b00};
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    got = cfg_prdata;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    if (got !== model_reg(idx)) report_mismatch($sformatf("register %0d", idx),
                                                int'(got), int'(model_reg(idx)));
  endtask

  task automatic apply_setting(input int duty, input int period, input int light,
                               input int filt, input int half, input int hold);
    int k;
    wait_idle();
    repeat (4) @(posedge clk);
    reg_write(REG_DUTY, duty, 8);
    reg_write(REG_PERIOD, period, 8);
    reg_write(REG_LIGHT, light, 8);
    reg_write(REG_IR_FILT, filt, 8);
    reg_write(REG_IR_HALF, half, 4);
    reg_write(REG_ESC_HOLD, hold, 13);
    // writes past the map are dropped
    reg_write(REG_SPARE_A, $urandom(), 32);
    reg_write(REG_SPARE_B, $urandom(), 32);
    for (k = 0; k < 6; k++) reg_readback(3'(k));
  endtask

  // Tick transfer bookkeeping: predict at acceptance
  always @(posedge clk) begin
    tick_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && in_tvalid && in_tready)
      expected_results.push_back(sequence_tick(drive_item));
  end

  // Tick driver
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || tick_taken) begin
      if (pending_ticks.size() != 0 && $urandom_range(99, 0) >= send_idle_pct) begin
        drive_item = pending_ticks.pop_front();
        in_tdata <= {5'd0, drive_item};
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else        out_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
  end

  // Result monitor
  always @(posedge clk) begin
    rtsq_out_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[13:0];
      if (expected_results.size() == 0) begin
        report_mismatch("result with no tick pending", int'(out_tdata), 0);
      end else begin
        want = expected_results.pop_front();
        if (got.motor_port_value !== want.motor_port_value)
          report_mismatch("motor_port_value", int'(got.motor_port_value),
                          int'(want.motor_port_value));
        if (got.motor_port_write !== want.motor_port_write)
          report_mismatch("motor_port_write", int'(got.motor_port_write),
                          int'(want.motor_port_write));
        if (got.ir_emitter !== want.ir_emitter)
          report_mismatch("ir_emitter", int'(got.ir_emitter), int'(want.ir_emitter));
        if (got.obstacle_flag !== want.obstacle_flag)
          report_mismatch("obstacle_flag", int'(got.obstacle_flag),
                          int'(want.obstacle_flag));
        if (got.active_mode !== want.active_mode)
          report_mismatch("active_mode", int'(got.active_mode), int'(want.active_mode));
      end
    end
  end

  // Run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Phase settings: duty, period, light, filter, half period, hold
  int set_duty[PHASES]   = '{3, 12, 255, 0, 5, 95, 2};
  int set_period[PHASES] = '{8, 5, 255, 0, 10, 100, 3};
  int set_light[PHASES]  = '{200, 180, 255, 0, 150, 200, 240};
  int set_filt[PHASES]   = '{2, 0, 255, 1, 3, 100, 4};
  int set_half[PHASES]   = '{1, 2, 15, 0, 3, 3, 2};
  int set_hold[PHASES]   = '{20, 1, 8191, 0, 50, 5000, 7};

  initial begin
    logic [7:0] sweep[15];
    int p, i;
    sweep = '{10, 11, 31, 32, 52, 53, 74, 75, 95, 96, 116, 117, 137, 138, 255};
    model_reset();
    send_idle_pct = 24;
    recv_idle_pct = 60;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults: cruise, blind above the limit, light at the limit
    queue_tick(8'd0, 8'd0, 1'b0, 1'b0, 2'd0);
    queue_tick(8'd255, 8'd0, 1'b1, 1'b0, 2'd3);
    queue_tick(8'd200, 8'd10, 1'b0, 1'b0, 2'd1);
    queue_tick(8'd201, 8'd0, 1'b1, 1'b0, 2'd2);

    // Short period, zero hold, zero half period, zero filter
    apply_setting(1, 2, 128, 0, 0, 0);
    for (i = 0; i < 15; i++)
      queue_tick(8'd0, sweep[i], i[0], 1'b0, 2'(i));
    for (i = 0; i < 5; i++)
      queue_tick(8'd0, 8'd0, 1'b0, 1'b1, 2'(i + 1));
    // blind while an escape code is present
    queue_tick(8'd255, 8'd255, 1'b1, 1'b0, 2'd3);

    for (p = 0; p < PHASES; p++) begin
      apply_setting(set_duty[p], set_period[p], set_light[p],
                    set_filt[p], set_half[p], set_hold[p]);
      if (p < 3) begin
        send_idle_pct = 24;
        recv_idle_pct = 60;
      end else if (p < 5) begin
        send_idle_pct = 60;
        recv_idle_pct = 24;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      queue_random(PHASE_TICKS);
    end

    wait_idle();
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch("results never arrived", 0, expected_results.size());
    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
